@@ design/pva_pkg.sv @@
package pva_pkg;

  localparam int unsigned ChanW   = 16;
  localparam int unsigned VibW    = 16;
  localparam int unsigned NumChan = 3;
  localparam int unsigned NumStg  = 6;

  localparam int unsigned D3W   = ChanW + 1;
  localparam int unsigned P1W   = ChanW + D3W;
  localparam int unsigned P2W   = P1W + VibW;
  localparam int unsigned RndW  = P2W + 1;
  localparam int unsigned RndSh = 30;
  localparam int unsigned TW    = RndW - RndSh;
  localparam int unsigned RcpW  = 20;
  localparam int unsigned RcpSh = 21;
  localparam int unsigned QW    = TW + RcpW - RcpSh;

  // 3 * 2^30 / 2, rounding offset ahead of the shift by 30
  localparam logic [RndW-1:0] AdjHalf  = RndW'(64'd1610612736);
  // (2^21 + 1) / 3, exact floor(t / 3) for t < 2^21
  localparam logic [RcpW-1:0] RecipDiv3 = RcpW'(32'd699051);

  typedef logic [NumChan-1:0][ChanW-1:0] pix_t;

endpackage

@@ design/pva_pix_in_if.sv @@
interface pva_pix_in_if;
  import pva_pkg::*;

  logic             valid;
  logic             ready;
  logic [ChanW-1:0] red_in;
  logic [ChanW-1:0] green_in;
  logic [ChanW-1:0] blue_in;

  modport source (output valid, output red_in, output green_in, output blue_in, input ready);
  modport sink (input valid, input red_in, input green_in, input blue_in, output ready);
endinterface

@@ design/pva_pix_out_if.sv @@
interface pva_pix_out_if;
  import pva_pkg::*;

  logic             valid;
  logic             ready;
  logic [ChanW-1:0] red_out;
  logic [ChanW-1:0] green_out;
  logic [ChanW-1:0] blue_out;

  modport source (output valid, output red_out, output green_out, output blue_out, input ready);
  modport sink (input valid, input red_out, input green_out, input blue_out, output ready);
endinterface

@@ design/pva_cfg_if.sv @@
interface pva_cfg_if;
  import pva_pkg::*;

  logic                   valid;
  logic                   ready;
  logic signed [VibW-1:0] vibrance;

  modport source (output valid, output vibrance, input ready);
  modport sink (input valid, input vibrance, output ready);
endinterface

@@ design/pixel_vibrance_adjust.sv @@
// Throughput: one pixel per clock unless stalled; six register stages, each
// with its own valid bit, and a stalled output backs up only the full stages.
// Reset: valid bits cleared, vibrance set to 0 (pixels pass unchanged).
// Config writes are always accepted.
module pixel_vibrance_adjust (
  input  logic          clk_i,
  input  logic          rst_ni,
  pva_cfg_if.sink       cfg_i,
  pva_pix_in_if.sink    pix_i,
  pva_pix_out_if.source pix_o
);
  import pva_pkg::*;

  logic signed [VibW-1:0] vib_q;
  logic [VibW-1:0]        mag;
  logic                   add;

  logic [NumStg-1:0] vld_q;
  logic [NumStg-1:0] rdy;

  pix_t c_in, c1_q, c2_q, c3_q, c4_q, c5_q, out_q, out_d;
  logic [ChanW-1:0] mx;
  logic [ChanW+1:0] sum3, mx3;
  logic [D3W-1:0]   d3, d3_q;

  logic [NumChan-1:0][ChanW-1:0] diff, diff_q;
  logic [NumChan-1:0][P1W-1:0]   p1, p1_q;
  logic [NumChan-1:0][P2W-1:0]   p2, p2_q;
  logic [NumChan-1:0][TW-1:0]    t, t_q;
  logic [NumChan-1:0][QW-1:0]    q, q_q;
  logic [NumChan-1:0][RndW-1:0]  rnd;
  logic [NumChan-1:0][TW+RcpW-1:0] rcp;
  logic [NumChan-1:0][QW:0]      up;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vib_q <= '0;
    end else if (cfg_i.valid) begin
      vib_q <= cfg_i.vibrance;
    end
  end

  assign add = vib_q[VibW-1];
  assign mag = add ? VibW'(~vib_q + 1'b1) : VibW'(vib_q);

  // per-stage backpressure
  always_comb begin
    rdy[NumStg-1] = !vld_q[NumStg-1] || pix_o.ready;
    for (int k = NumStg - 2; k >= 0; k--) begin
      rdy[k] = !vld_q[k] || rdy[k+1];
    end
  end

  assign pix_i.ready = rdy[0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      if (rdy[0]) vld_q[0] <= pix_i.valid;
      for (int k = 1; k < NumStg; k++) begin
        if (rdy[k]) vld_q[k] <= vld_q[k-1];
      end
    end
  end

  // max, 3*(max - mean), distance to max
  always_comb begin
    c_in = {pix_i.blue_in, pix_i.green_in, pix_i.red_in};
    mx   = (c_in[0] > c_in[1]) ? c_in[0] : c_in[1];
    mx   = (mx > c_in[2]) ? mx : c_in[2];
    sum3 = (ChanW+2)'(c_in[0]) + (ChanW+2)'(c_in[1]) + (ChanW+2)'(c_in[2]);
    mx3  = ((ChanW+2)'(mx) << 1) + (ChanW+2)'(mx);
    d3   = D3W'(mx3 - sum3);
    for (int i = 0; i < NumChan; i++) begin
      diff[i] = mx - c_in[i];
    end
  end

  always_comb begin
    for (int i = 0; i < NumChan; i++) begin
      p1[i]  = P1W'(diff_q[i]) * P1W'(d3_q);
      p2[i]  = P2W'(p1_q[i]) * P2W'(mag);
      rnd[i] = RndW'(p2_q[i]) + AdjHalf;
      t[i]   = rnd[i][RndW-1:RndSh];
      rcp[i] = (TW+RcpW)'(t_q[i]) * (TW+RcpW)'(RecipDiv3);
      q[i]   = rcp[i][TW+RcpW-1:RcpSh];
      up[i]  = (QW+1)'(c5_q[i]) + (QW+1)'(q_q[i]);
      if (add) begin
        out_d[i] = (up[i][QW:ChanW] != '0) ? '1 : up[i][ChanW-1:0];
      end else begin
        out_d[i] = (q_q[i] > QW'(c5_q[i])) ? '0 : c5_q[i] - q_q[i][ChanW-1:0];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy[0] && pix_i.valid) begin
      c1_q   <= c_in;
      diff_q <= diff;
      d3_q   <= d3;
    end
    if (rdy[1] && vld_q[0]) begin
      c2_q <= c1_q;
      p1_q <= p1;
    end
    if (rdy[2] && vld_q[1]) begin
      c3_q <= c2_q;
      p2_q <= p2;
    end
    if (rdy[3] && vld_q[2]) begin
      c4_q <= c3_q;
      t_q  <= t;
    end
    if (rdy[4] && vld_q[3]) begin
      c5_q <= c4_q;
      q_q  <= q;
    end
    if (rdy[5] && vld_q[4]) begin
      out_q <= out_d;
    end
  end

  assign pix_o.valid     = vld_q[NumStg-1];
  assign pix_o.red_out   = out_q[0];
  assign pix_o.green_out = out_q[1];
  assign pix_o.blue_out  = out_q[2];

endmodule
